/* src/fksm_pkg.sv */
// Shared types and constants for the fixed-length key set match block.
package fksm_pkg;

   localparam int KEY_FIELD_W   = 64;
   localparam int DEF_KEY_BYTES = 8;
   localparam int DEF_MAX_KEYS  = 256;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;    // latch request word, restart sweep
      logic sweep;   // issue store reads and compare
      logic finish;  // commit insert, drive response
   } cmd_type;

   typedef struct packed {
      logic done;    // sweep ended: hit seen or all filled entries compared
   } status_type;

endpackage

/* src/fksm_ctrl.sv */
// Controller state machine for the key set match block.
module fksm_ctrl
   import fksm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* src/fksm_dpath.sv */
// Datapath for the key set match block: key store, sweep counter, compare, response.
module fksm_dpath
   import fksm_pkg::*;
#(
   parameter int KEY_BYTES = DEF_KEY_BYTES,
   parameter int MAX_KEYS  = DEF_MAX_KEYS
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_type,
   input  logic [KEY_FIELD_W-1:0] req_key,
   input  cmd_type                cmd,
   output status_type             status,
   output logic                   rsp_strobe,
   output logic                   rsp_found,
   output logic                   rsp_full_res
);

   localparam int KEY_W  = 8 * KEY_BYTES;
   localparam int ADDR_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CNT_W  = $clog2(MAX_KEYS + 1);

   logic [KEY_W-1:0] store_mem [MAX_KEYS];

   logic [KEY_W-1:0] key_ff;
   logic             type_ff;
   logic [CNT_W-1:0] fill_ff,  fill_in;
   logic [CNT_W-1:0] idx_ff,   idx_in;
   logic             pend_ff,  pend_in;
   logic             hit_ff,   hit_in;
   logic [KEY_W-1:0] rd_data_ff;
   logic             rsp_strobe_ff, rsp_found_ff, rsp_full_ff;

   logic match;
   logic issue;
   logic is_full;
   logic do_write;

   // compare the word read last cycle; stop issuing once a hit is known
   assign match    = pend_ff && (rd_data_ff == key_ff);
   assign issue    = cmd.sweep && (idx_ff != fill_ff) && !hit_ff && !match;
   assign is_full  = (fill_ff == CNT_W'(MAX_KEYS));
   assign do_write = cmd.finish && (type_ff == REQ_INSERT) && !hit_ff && !is_full;

   assign status.done = !pend_ff && (hit_ff || (idx_ff == fill_ff));

   always_comb begin
      idx_in  = idx_ff;
      pend_in = issue;
      hit_in  = hit_ff || match;
      fill_in = fill_ff;
      if (cmd.load) begin
         idx_in  = '0;
         hit_in  = 1'b0;
         pend_in = 1'b0;
      end else if (issue) begin
         idx_in = idx_ff + 1'b1;
      end
      if (do_write) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         idx_ff        <= idx_in;
         pend_ff       <= pend_in;
         hit_ff        <= hit_in;
         rsp_strobe_ff <= cmd.finish;
      end
   end

   // request word and response payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff  <= req_key[KEY_W-1:0];
         type_ff <= req_type;
      end
      if (cmd.finish) begin
         rsp_found_ff <= hit_ff;
         rsp_full_ff  <= (type_ff == REQ_INSERT) && !hit_ff && is_full;
      end
   end

   // key store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_write) begin
         store_mem[fill_ff[ADDR_W-1:0]] <= key_ff;
      end
      if (issue) begin
         rd_data_ff <= store_mem[idx_ff[ADDR_W-1:0]];
      end
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_full_res = rsp_full_ff;

endmodule

/* src/fixed_length_key_set_match.sv */
// Top level of the fixed-length key set match block.
//
//  channel   ports                              handshake
//  request   req_type, req_key                  taken when start & !busy
//  response  rsp_found, rsp_full_res            one cycle, marked by rsp_strobe
//
// From one accepting edge to the next an item passes these steps in order: a read
// of each stored key through the single read port of the key store (ending early
// on a hit, none on an empty set), the compare of the registered read data, a
// closing step after the last compare, the commit, and the response. The response
// word shows in the cycle after the commit cycle; busy drops with it, so the next
// word can be taken at its closing edge.
// Reset (synchronous, active high) empties the set by clearing the fill count;
// store contents are never read before they are written.
// The receiver cannot stall: rsp_strobe is a single-cycle pulse.
module fixed_length_key_set_match
   import fksm_pkg::*;
#(
   parameter int KEY_BYTES = DEF_KEY_BYTES,
   parameter int MAX_KEYS  = DEF_MAX_KEYS
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_type,
   input  logic [KEY_FIELD_W-1:0] req_key,
   output logic                   rsp_strobe,
   output logic                   rsp_found,
   output logic                   rsp_full_res
);

   cmd_type    cmd;
   status_type status;

   // sequencer: idle -> sweep the store -> finish
   fksm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // key store, compare and response registers
   fksm_dpath #(
      .KEY_BYTES (KEY_BYTES),
      .MAX_KEYS  (MAX_KEYS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_type     (req_type),
      .req_key      (req_key),
      .cmd          (cmd),
      .status       (status),
      .rsp_strobe   (rsp_strobe),
      .rsp_found    (rsp_found),
      .rsp_full_res (rsp_full_res)
   );

endmodule

/* sim/tb.sv */
// Self-checking testbench for the fixed-length key set match block.
`timescale 1ns / 1ps

module tb;
   import fksm_pkg::*;

   // Block configuration under test: the defaults from the package.
   localparam int KEY_BYTES = DEF_KEY_BYTES;
   localparam int MAX_KEYS  = DEF_MAX_KEYS;
   localparam int PERIOD    = 20;

   // Key bits that take part in a compare; the rest of the field is ignored.
   localparam logic [KEY_FIELD_W-1:0] KEY_MASK =
      (KEY_BYTES >= 8) ? {KEY_FIELD_W{1'b1}}
                       : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

   // Worst item: a full sweep of the store plus latch, read latency, commit
   // and the response cycle. Used for the quiet period at the end.
   localparam int SETTLE_CYCLES = MAX_KEYS + 16;
   localparam int NUM_RANDOM    = 800;
   localparam int PRINT_CAP     = 100;

   // One request word as the sender will drive it.
   typedef struct {
      logic                   rtype;
      logic [KEY_FIELD_W-1:0] key;
      bit                     drain_first;  // hold off until all answers are in
   } key_word_type;

   // One predicted response word, with the request that caused it.
   typedef struct {
      logic                   found;
      logic                   full_res;
      logic                   rtype;
      logic [KEY_FIELD_W-1:0] key;
      int unsigned            seq;
   } answer_type;

   // DUT signals
   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   start        = 1'b0;
   logic                   req_type     = REQ_INSERT;
   logic [KEY_FIELD_W-1:0] req_key      = '0;
   logic                   busy;
   logic                   rsp_strobe;
   logic                   rsp_found;
   logic                   rsp_full_res;

   // Stimulus and prediction state
   key_word_type           words_pending[$];
   answer_type             answers_due[$];
   logic [KEY_FIELD_W-1:0] key_pool[$];      // keys the generator has inserted
   logic [KEY_FIELD_W-1:0] set_keys[MAX_KEYS];
   int unsigned            set_fill     = 0;

   // Driver pacing
   logic                   word_taken   = 1'b0;
   int unsigned            burst_left   = 1;
   int unsigned            gap_left     = 0;

   // Counters
   int unsigned            n_total      = 0;
   int unsigned            n_taken      = 0;
   int unsigned            n_checked    = 0;
   int unsigned            n_inserts    = 0;
   int unsigned            n_lookups    = 0;
   int unsigned            n_hits       = 0;
   int unsigned            n_dropped    = 0;
   int unsigned            n_drains     = 0;
   int unsigned            n_errors     = 0;

   fixed_length_key_set_match #(
      .KEY_BYTES (KEY_BYTES),
      .MAX_KEYS  (MAX_KEYS)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_type     (req_type),
      .req_key      (req_key),
      .rsp_strobe   (rsp_strobe),
      .rsp_found    (rsp_found),
      .rsp_full_res (rsp_full_res)
   );

   always #(PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // Key set predictor: sweep the filled entries for an exact match on
   // the masked key; an insert of a new key appends it while there is
   // room, otherwise it is dropped and flagged full. Lookups never touch
   // the set and never flag full.
   // ------------------------------------------------------------------
   task automatic predict_answer(input logic rtype, input logic [KEY_FIELD_W-1:0] raw_key);
      logic [KEY_FIELD_W-1:0] k;
      answer_type             a;
      bit                     hit;
      k   = raw_key & KEY_MASK;
      hit = 1'b0;
      for (int i = 0; i < set_fill; i++) begin
         if (set_keys[i] == k) hit = 1'b1;
      end
      a.found    = hit;
      a.full_res = 1'b0;
      a.rtype    = rtype;
      a.key      = raw_key;
      a.seq      = n_taken;
      if (rtype == REQ_INSERT) begin
         n_inserts++;
         if (!hit) begin
            if (set_fill >= MAX_KEYS) begin
               a.full_res = 1'b1;
               n_dropped++;
            end else begin
               set_keys[set_fill] = k;
               set_fill++;
            end
         end
      end else begin
         n_lookups++;
      end
      if (hit) n_hits++;
      answers_due = {answers_due, a};
   endtask

   // One line per mismatch; printing stops after PRINT_CAP, counting does not.
   task automatic report_mismatch(input string what, input int unsigned seq,
                                  input logic [KEY_FIELD_W-1:0] key,
                                  input logic got, input logic want);
      n_errors++;
      if (n_errors <= PRINT_CAP)
         $display("MISMATCH t=%0t word %0d key %h: %s got %b want %b",
                  $time, seq, key, what, got, want);
   endtask

   task automatic add_word(input logic rtype, input logic [KEY_FIELD_W-1:0] key,
                           input bit drain_first);
      key_word_type w;
      w.rtype       = rtype;
      w.key         = key;
      w.drain_first = drain_first;
      words_pending = {words_pending, w};
      if (rtype == REQ_INSERT) key_pool = {key_pool, key};
      n_total++;
   endtask

   // ------------------------------------------------------------------
   // Acceptance: a word goes in at a rising edge with start high and busy
   // low. Values sampled here are the ones from before the edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         word_taken <= 1'b0;
      end else begin
         word_taken <= start && !busy;
         if (start && !busy) begin
            predict_answer(req_type, req_key);
            n_taken++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Driver: changes inputs on the falling edge. A word stays on the bus
   // until it is taken; between bursts the sender idles for a random gap.
   // A word marked drain_first waits until every answer has come back.
   // ------------------------------------------------------------------
   always @(negedge clock) begin : drive
      key_word_type w;
      if (!reset) begin
         if (start && !word_taken) begin
            // still waiting for the block to take the current word
         end else if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (words_pending.size() == 0) begin
            start <= 1'b0;
         end else if (words_pending[0].drain_first && answers_due.size() != 0) begin
            start <= 1'b0;
         end else begin
            w = words_pending.pop_front();
            if (w.drain_first) n_drains++;
            start    <= 1'b1;
            req_type <= w.rtype;
            req_key  <= w.key;
            if (burst_left > 1) begin
               burst_left <= burst_left - 1;
            end else begin
               // Next burst: mostly short, now and then a long stretch with
               // no idling. Gaps range from none to past a full sweep.
               burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 12);
               case ($urandom_range(0, 9))
                  0, 1, 2: gap_left <= 0;
                  9:       gap_left <= $urandom_range(40, 320);
                  default: gap_left <= $urandom_range(1, 30);
               endcase
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: each strobe carries one response word, checked against the
   // oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      answer_type due;
      if (!reset && rsp_strobe) begin
         if (answers_due.size() == 0) begin
            report_mismatch("response with nothing outstanding", n_checked, req_key,
                            rsp_found, 1'b0);
         end else begin
            due = answers_due.pop_front();
            if (rsp_found !== due.found)
               report_mismatch("found", due.seq, due.key, rsp_found, due.found);
            if (rsp_full_res !== due.full_res)
               report_mismatch("full_res", due.seq, due.key, rsp_full_res, due.full_res);
            n_checked++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus, reset and end of run.
   // ------------------------------------------------------------------
   initial begin
      logic [KEY_FIELD_W-1:0] k;
      int unsigned            r;

      // Directed words: field extremes, duplicates, hits, near misses.
      add_word(REQ_INSERT, 64'h0000_0000_0000_0000, 1'b0);
      add_word(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      add_word(REQ_INSERT, 64'h0000_0000_0000_0000, 1'b0);   // duplicate insert
      add_word(REQ_LOOKUP, 64'h0000_0000_0000_0000, 1'b0);   // hit on first entry
      add_word(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);   // hit on last entry
      add_word(REQ_LOOKUP, 64'h0000_0000_0000_0001, 1'b0);   // miss, one bit off
      add_word(REQ_LOOKUP, 64'h8000_0000_0000_0000, 1'b0);   // miss, top bit
      add_word(REQ_INSERT, 64'h8000_0000_0000_0000, 1'b0);
      add_word(REQ_LOOKUP, 64'h8000_0000_0000_0000, 1'b0);
      add_word(REQ_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);   // near miss of all ones
      add_word(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
      add_word(REQ_INSERT, 64'h0123_4567_89AB_CDEF, 1'b0);
      add_word(REQ_LOOKUP, 64'h0123_4567_89AB_CDEF, 1'b0);
      add_word(REQ_LOOKUP, 64'h0123_4567_89AB_CDEE, 1'b0);   // last byte differs
      add_word(REQ_LOOKUP, 64'h1123_4567_89AB_CDEF, 1'b0);   // first byte differs
      add_word(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);   // duplicate of all ones
      add_word(REQ_INSERT, 64'h0000_0000_0000_0001, 1'b0);
      add_word(REQ_LOOKUP, 64'h0000_0000_0000_0001, 1'b0);
      add_word(REQ_INSERT, 64'hFEDC_BA98_7654_3210, 1'b0);
      add_word(REQ_INSERT, 64'hFEDC_BA98_7654_3210, 1'b0);   // duplicate of the last entry

      // Random words. Fresh inserts fill the set to MAX_KEYS part way
      // through, so the later part exercises drops on a full set, while
      // pooled keys keep hits and duplicates frequent all along.
      for (int n = 0; n < NUM_RANDOM; n++) begin
         r = $urandom_range(0, 99);
         if (r < 45 || key_pool.size() == 0) begin
            k = {$urandom, $urandom};
            add_word(REQ_INSERT, k, (n == 0) || ($urandom_range(0, 49) == 0));
         end else begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            if (r < 60) begin
               add_word(REQ_INSERT, k, $urandom_range(0, 49) == 0);
            end else if (r < 78) begin
               add_word(REQ_LOOKUP, k, $urandom_range(0, 49) == 0);
            end else if (r < 90) begin
               k[$urandom_range(0, KEY_FIELD_W - 1)] ^= 1'b1;   // near miss
               add_word(REQ_LOOKUP, k, $urandom_range(0, 49) == 0);
            end else begin
               add_word(REQ_LOOKUP, {$urandom, $urandom}, $urandom_range(0, 49) == 0);
            end
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for all words to be taken and answered, then stay quiet for a
      // full sweep so a stray strobe would still be caught.
      while (n_taken != n_total || answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d request words (%0d inserts, %0d lookups), %0d responses checked.",
               n_total, n_inserts, n_lookups, n_checked);
      $display("Hits %0d, inserts dropped on a full set %0d, set fill %0d of %0d, drains %0d.",
               n_hits, n_dropped, set_fill, MAX_KEYS, n_drains);
      if (n_errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Hang guard, several times the slowest legal run.
   initial begin
      #40_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
